>>> hw/rtl/fmo_pkg.sv
`default_nettype none

package fmo_pkg;

  // Geometry of the sine table and phase words
  localparam int TABLE_BITS   = 10;
  localparam int TABLE_SIZE   = 1 << TABLE_BITS;
  localparam int FRAC_W       = 16;
  localparam int PHASE_W      = TABLE_BITS + FRAC_W;
  localparam int QUAD_BITS    = TABLE_BITS - 2;
  localparam int QTAB_DEPTH   = TABLE_SIZE / 4 + 1;
  localparam int QTAB_AW      = QUAD_BITS + 1;
  localparam int MAG_W        = 15;
  localparam int SAMPLE_W     = 16;

  // Modulators
  localparam int NUM_MODS     = 8;
  localparam int MOD_IDX_W    = 3;
  localparam int MOD_CNT_W    = 4;

  // Field widths
  localparam int STEP_W       = 26;
  localparam int HARM_W       = 16;
  localparam int DEPTH_W      = 24;
  localparam int IN_DATA_W    = 32;

  // Shared multiplier
  localparam int MUL_A_W      = 26;
  localparam int MUL_B_W      = 24;
  localparam int MUL_P_W      = MUL_A_W + MUL_B_W;

  // Configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_HARM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MODS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_SELECT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_HARM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH    = 3'd4;

  localparam logic [HARM_W-1:0] CARRIER_HARM_RST = 16'd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAR,
    ST_RDA,
    ST_RDB,
    ST_DIF,
    ST_INT,
    ST_DEP,
    ST_MOD,
    ST_ADV,
    ST_DONE
  } fmo_state_t;

  typedef struct packed {
    logic [HARM_W-1:0]    carrier_harm;
    logic [MOD_CNT_W-1:0] n_active;
    logic                 clear_ph;
  } fmo_cfg_t;

  // Quarter-wave sine magnitude table, built at elaboration with a Q30 Taylor series
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam int          QS_SHIFT    = 32 - TABLE_BITS;
  localparam logic [63:0] QS_DIV [13] = '{64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                         64'd156, 64'd210, 64'd272, 64'd342, 64'd420,
                                         64'd506, 64'd600};

  typedef logic [MAG_W-1:0] qtab_t [QTAB_DEPTH];

  function automatic logic [MAG_W-1:0] qsine_mag(input int unsigned q);
    logic [63:0] t;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] mag;
    longint      sum;
    t    = 64'(q) << QS_SHIFT;
    a    = (t * HALF_PI_Q30) >> 30;
    a2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * a2) >> 30) / QS_DIV[k];
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(Q30_ONE)) begin
      sum = longint'(Q30_ONE);
    end
    s   = 64'(sum);
    mag = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    return mag[MAG_W-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int i = 0; i < QTAB_DEPTH; i++) begin
      tab[i] = qsine_mag(i);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

`default_nettype wire

>>> hw/rtl/fmo_mul.sv
`default_nettype none

// Shared signed multiplier, product registered
module fmo_mul (
  input  wire                                  clk,
  input  wire logic signed [fmo_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [fmo_pkg::MUL_B_W-1:0] b,
  output logic signed [fmo_pkg::MUL_P_W-1:0]      p_r
);

  logic signed [fmo_pkg::MUL_P_W-1:0] p_nxt;

  always_comb begin
    p_nxt = fmo_pkg::MUL_P_W'(a) * fmo_pkg::MUL_P_W'(b);
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/fmo_sine.sv
`default_nettype none

// Full-period sine from quarter-wave table, registered read
module fmo_sine (
  input  wire                                clk,
  input  wire logic [fmo_pkg::TABLE_BITS-1:0] idx,
  output logic signed [fmo_pkg::SAMPLE_W-1:0] val_r
);

  logic [1:0]                          quad;
  logic [fmo_pkg::QUAD_BITS-1:0]       q;
  logic [fmo_pkg::QTAB_AW-1:0]         addr;
  logic signed [fmo_pkg::SAMPLE_W-1:0] mag_s;
  logic signed [fmo_pkg::SAMPLE_W-1:0] val_nxt;

  always_comb begin
    quad = idx[fmo_pkg::TABLE_BITS-1 -: 2];
    q    = idx[fmo_pkg::QUAD_BITS-1:0];
    // odd quadrants run the table backwards
    if (quad[0]) begin
      addr = fmo_pkg::QTAB_AW'(fmo_pkg::QTAB_DEPTH - 1) - {1'b0, q};
    end else begin
      addr = {1'b0, q};
    end
    mag_s   = $signed({1'b0, fmo_pkg::QTAB[addr]});
    val_nxt = quad[1] ? -mag_s : mag_s;
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/fmo_cfg.sv
`default_nettype none

// Configuration registers and per-modulator harmonic/depth tables
module fmo_cfg (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fmo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fmo_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [fmo_pkg::MOD_IDX_W-1:0]     rd_idx,
  output fmo_pkg::fmo_cfg_t                      ctrl,
  output logic [fmo_pkg::HARM_W-1:0]             rd_harm,
  output logic signed [fmo_pkg::DEPTH_W-1:0]     rd_depth
);

  logic [fmo_pkg::HARM_W-1:0]         carrier_harm_r;
  logic [fmo_pkg::MOD_CNT_W-1:0]      active_r;
  logic [fmo_pkg::MOD_IDX_W-1:0]      sel_r;
  logic [fmo_pkg::HARM_W-1:0]         harm_r  [fmo_pkg::NUM_MODS];
  logic signed [fmo_pkg::DEPTH_W-1:0] depth_r [fmo_pkg::NUM_MODS];
  logic                               wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_harm_r <= fmo_pkg::CARRIER_HARM_RST;
      active_r       <= '0;
      sel_r          <= '0;
      for (int i = 0; i < fmo_pkg::NUM_MODS; i++) begin
        harm_r[i]  <= '0;
        depth_r[i] <= '0;
      end
    end else if (wr) begin
      case (cfg_index)
        fmo_pkg::REG_CARRIER_HARM: carrier_harm_r <= cfg_data[fmo_pkg::HARM_W-1:0];
        fmo_pkg::REG_ACTIVE_MODS:  active_r       <= cfg_data[fmo_pkg::MOD_CNT_W-1:0];
        fmo_pkg::REG_MOD_SELECT:   sel_r          <= cfg_data[fmo_pkg::MOD_IDX_W-1:0];
        fmo_pkg::REG_MOD_HARM:     harm_r[sel_r]  <= cfg_data[fmo_pkg::HARM_W-1:0];
        fmo_pkg::REG_MOD_DEPTH:    depth_r[sel_r] <= $signed(cfg_data[fmo_pkg::DEPTH_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl.carrier_harm = carrier_harm_r;
    // counts above the modulator bank saturate
    if (active_r > fmo_pkg::MOD_CNT_W'(fmo_pkg::NUM_MODS)) begin
      ctrl.n_active = fmo_pkg::MOD_CNT_W'(fmo_pkg::NUM_MODS);
    end else begin
      ctrl.n_active = active_r;
    end
    ctrl.clear_ph = wr && (cfg_index == fmo_pkg::REG_MOD_HARM);
    rd_harm       = harm_r[rd_idx];
    rd_depth      = depth_r[rd_idx];
  end

endmodule

`default_nettype wire

>>> hw/rtl/fm_oscillator_parallel_modulators.sv
// FM oscillator, parallel sine modulators, one shared multiplier under a sequencer.
// Per request: carrier advance; then per active modulator (0..8) table reads, interpolation,
// depth product, phase advance; then the carrier read. One request at a time; every step
// uses the one multiplier and single-port sine table (two reads, three products per modulator).
// Reset (rst_n low, synchronous): phases cleared, carrier harmonic 1.0, no modulators active,
// output channel empty. The sine table is constant logic and needs no fill.
`default_nettype none

module fm_oscillator_parallel_modulators (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // in_tdata: [25:0] fundamental_step (signed), [31:26] zero
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire logic [fmo_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: [15:0] sample_out (signed Q1.15)
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [fmo_pkg::SAMPLE_W-1:0]        out_tdata,
  // configuration write channel
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fmo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fmo_pkg::CFG_DATA_W-1:0] cfg_data
);

  fmo_pkg::fmo_state_t state_r, state_nxt;

  fmo_pkg::fmo_cfg_t                   cfg_ctrl;
  logic [fmo_pkg::HARM_W-1:0]          harm_j;
  logic signed [fmo_pkg::DEPTH_W-1:0]  depth_j;

  // phase state
  logic [fmo_pkg::PHASE_W-1:0]         carrier_r;
  logic [fmo_pkg::PHASE_W-1:0]         mod_ph_r [fmo_pkg::NUM_MODS];

  // per-request working registers
  logic signed [fmo_pkg::STEP_W-1:0]   step_r;
  logic [fmo_pkg::PHASE_W-1:0]         acc_r;      // modulated carrier phase
  logic [fmo_pkg::MOD_IDX_W-1:0]       j_r;
  logic [fmo_pkg::MOD_CNT_W-1:0]       n_r;
  logic                                fin_r;      // interpolating the carrier itself
  logic signed [fmo_pkg::SAMPLE_W-1:0] ya_r;
  logic signed [fmo_pkg::SAMPLE_W-1:0] s_r;

  // output register
  logic                                out_valid_r;
  logic signed [fmo_pkg::SAMPLE_W-1:0] out_data_r;

  // datapath
  logic [fmo_pkg::PHASE_W-1:0]         p;
  logic [fmo_pkg::TABLE_BITS-1:0]      sine_idx;
  logic signed [fmo_pkg::SAMPLE_W-1:0] sine_val;
  logic signed [fmo_pkg::SAMPLE_W:0]   diff;
  logic signed [fmo_pkg::SAMPLE_W-1:0] s_new;
  logic signed [fmo_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [fmo_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [fmo_pkg::MUL_P_W-1:0]  prod;
  logic [fmo_pkg::PHASE_W-1:0]         adv;        // floor(prod / 256), wrapped
  logic [fmo_pkg::PHASE_W-1:0]         mod_term;   // floor(prod / 32), wrapped
  logic [fmo_pkg::MOD_CNT_W-1:0]       j_inc;
  logic                                accept;
  logic                                done_go;

  fmo_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_idx    (j_r),
    .ctrl      (cfg_ctrl),
    .rd_harm   (harm_j),
    .rd_depth  (depth_j)
  );

  fmo_sine u_sine (
    .clk   (clk),
    .idx   (sine_idx),
    .val_r (sine_val)
  );

  fmo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  // Phase under interpolation: a modulator's own phase, then the modulated carrier
  assign p        = fin_r ? acc_r : mod_ph_r[j_r];
  // second table read fetches the next entry, wrapping at the end of the table
  assign sine_idx = p[fmo_pkg::PHASE_W-1:fmo_pkg::FRAC_W]
                    + fmo_pkg::TABLE_BITS'(state_r == fmo_pkg::ST_RDB);
  assign diff     = {sine_val[fmo_pkg::SAMPLE_W-1], sine_val}
                    - {ya_r[fmo_pkg::SAMPLE_W-1], ya_r};
  // ya + floor((yb - ya) * frac / 65536); true result always fits 16 bits
  assign s_new    = ya_r + $signed(prod[fmo_pkg::FRAC_W +: fmo_pkg::SAMPLE_W]);
  assign adv      = prod[8 +: fmo_pkg::PHASE_W];
  // sine * depth * TABLE_SIZE / 32768 reduces to a floor shift by 5
  assign mod_term = prod[(15 - fmo_pkg::TABLE_BITS) +: fmo_pkg::PHASE_W];
  assign j_inc    = {1'b0, j_r} + fmo_pkg::MOD_CNT_W'(1);
  assign accept   = in_tvalid & in_tready;
  assign done_go  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sequencer and multiplier operand select
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      fmo_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        // carrier advance issued on the request itself
        mul_a     = $signed(in_tdata[fmo_pkg::STEP_W-1:0]);
        mul_b     = $signed({8'b0, cfg_ctrl.carrier_harm});
        if (in_tvalid) begin
          state_nxt = fmo_pkg::ST_CAR;
        end
      end
      fmo_pkg::ST_CAR: state_nxt = fmo_pkg::ST_RDA;
      fmo_pkg::ST_RDA: state_nxt = fmo_pkg::ST_RDB;
      fmo_pkg::ST_RDB: state_nxt = fmo_pkg::ST_DIF;
      fmo_pkg::ST_DIF: begin
        mul_a     = {{(fmo_pkg::MUL_A_W - fmo_pkg::SAMPLE_W - 1){diff[fmo_pkg::SAMPLE_W]}}, diff};
        mul_b     = $signed({8'b0, p[fmo_pkg::FRAC_W-1:0]});
        state_nxt = fmo_pkg::ST_INT;
      end
      fmo_pkg::ST_INT: state_nxt = fin_r ? fmo_pkg::ST_DONE : fmo_pkg::ST_DEP;
      fmo_pkg::ST_DEP: begin
        mul_a     = {{(fmo_pkg::MUL_A_W - fmo_pkg::SAMPLE_W){s_r[fmo_pkg::SAMPLE_W-1]}}, s_r};
        mul_b     = depth_j;
        state_nxt = fmo_pkg::ST_MOD;
      end
      fmo_pkg::ST_MOD: begin
        mul_a     = step_r;
        mul_b     = $signed({8'b0, harm_j});
        state_nxt = fmo_pkg::ST_ADV;
      end
      fmo_pkg::ST_ADV: state_nxt = fmo_pkg::ST_RDA;
      fmo_pkg::ST_DONE: begin
        if (done_go) begin
          state_nxt = fmo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fmo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fmo_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control: output valid, loop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      if (state_r == fmo_pkg::ST_DONE && done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == fmo_pkg::ST_CAR) begin
        fin_r <= (n_r == '0);
      end else if (state_r == fmo_pkg::ST_ADV && !(j_inc < n_r)) begin
        fin_r <= 1'b1;
      end
    end
  end

  // Phase state; a modulator harmonic write clears every phase
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_ctrl.clear_ph) begin
      carrier_r <= '0;
      for (int i = 0; i < fmo_pkg::NUM_MODS; i++) begin
        mod_ph_r[i] <= '0;
      end
    end else begin
      if (state_r == fmo_pkg::ST_CAR) begin
        carrier_r <= carrier_r + adv;
      end
      if (state_r == fmo_pkg::ST_ADV) begin
        mod_ph_r[j_r] <= mod_ph_r[j_r] + adv;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state_r)
      fmo_pkg::ST_IDLE: begin
        if (accept) begin
          step_r <= $signed(in_tdata[fmo_pkg::STEP_W-1:0]);
          acc_r  <= carrier_r;
          n_r    <= cfg_ctrl.n_active;
        end
      end
      fmo_pkg::ST_CAR: j_r  <= '0;
      fmo_pkg::ST_RDB: ya_r <= sine_val;
      fmo_pkg::ST_INT: s_r  <= s_new;
      fmo_pkg::ST_MOD: acc_r <= acc_r + mod_term;
      fmo_pkg::ST_ADV: begin
        if (j_inc < n_r) begin
          j_r <= j_r + fmo_pkg::MOD_IDX_W'(1);
        end
      end
      // sample lands in the output register only once the old one has gone
      fmo_pkg::ST_DONE: begin
        if (done_go) begin
          out_data_r <= s_r;
        end
      end
      default: ;
    endcase
  end

  // A request captures the old carrier phase as the modulation base
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == fmo_pkg::ST_CAR) && (acc_r == $past(carrier_r)))
    else $error("carrier phase not captured on request");

  // Modulator loop never runs past the active count
  a_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fmo_pkg::ST_DEP) |-> ({1'b0, j_r} < n_r) && !fin_r)
    else $error("modulator index beyond active count");

  // Results come only from the carrier interpolation
  a_done_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fmo_pkg::ST_DONE) |-> fin_r)
    else $error("result produced from a modulator interpolation");

  // Modulator harmonic write clears the phases
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ctrl.clear_ph |=> (carrier_r == '0) && (mod_ph_r[0] == '0))
    else $error("phases not cleared after harmonic write");

endmodule

`default_nettype wire

>>> tb/fmo_sample_check.sv
module fmo_sample_check (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  input  wire                                 in_tready,
  input  wire [fmo_pkg::IN_DATA_W-1:0]        in_tdata,
  input  wire                                 out_tvalid,
  input  wire                                 out_tready,
  input  wire [fmo_pkg::SAMPLE_W-1:0]         out_tdata,
  input  wire                                 cfg_valid,
  input  wire                                 cfg_ready,
  input  wire [fmo_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [fmo_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                  mismatch_count,
  output int                                  pending_count
);
  import fmo_pkg::*;

  localparam longint PHASE_MASK   = (longint'(1) << PHASE_W) - 1;
  localparam int     REPORT_LIMIT = 10;

  int     sine_tab [TABLE_SIZE];
  longint car_phase;
  longint mod_phase [NUM_MODS];
  longint mod_harm  [NUM_MODS];
  longint mod_depth [NUM_MODS];
  longint car_harm;
  int     active_mods;
  int     mod_sel;

  logic [SAMPLE_W-1:0] expected_samples [$];
  logic [SAMPLE_W-1:0] want;
  logic [SAMPLE_W-1:0] predicted;
  int                  errors;

  // sin(pi/2 * t), t and result in Q30, Taylor series to 25th order
  function automatic longint unsigned quarter_wave_q30(input longint unsigned t);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint unsigned div;
    longint          acc;
    int              k;
    a    = (t * 64'd1686629713) >> 30;
    a2   = (a * a) >> 30;
    term = a;
    acc  = longint'(a);
    for (k = 1; k <= 12; k++) begin
      div  = longint'(2 * k) * longint'(2 * k + 1);
      term = ((term * a2) >> 30) / div;
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(64'd1073741824)) begin
      acc = longint'(64'd1073741824);
    end
    return longint'(acc);
  endfunction

  initial begin : rom_build
    int              i;
    int              quad;
    longint unsigned r;
    longint unsigned mag;
    for (i = 0; i < TABLE_SIZE; i++) begin
      quad = (i >> (TABLE_BITS - 2)) & 3;
      r    = longint'(i & (TABLE_SIZE / 4 - 1)) << (32 - TABLE_BITS);
      if (quad % 2 == 1) begin
        r = 64'd1073741824 - r;
      end
      mag = (quarter_wave_q30(r) * 64'd32767 + 64'd536870912) >> 30;
      sine_tab[i] = (quad >= 2) ? -int'(mag) : int'(mag);
    end
  end

  // linear interpolation between neighboring entries, wraps past the last one
  function automatic longint interp_sine(input longint phase);
    longint p;
    longint frac;
    longint ya;
    longint yb;
    int     ia;
    p    = phase & PHASE_MASK;
    ia   = int'(p >> FRAC_W);
    frac = p & longint'(16'hFFFF);
    ya   = sine_tab[ia];
    yb   = sine_tab[(ia + 1) % TABLE_SIZE];
    return ya + (((yb - ya) * frac) >>> FRAC_W);
  endfunction

  task automatic clear_phases();
    car_phase = 0;
    for (int j = 0; j < NUM_MODS; j++) begin
      mod_phase[j] = 0;
    end
  endtask

  task automatic reset_voice();
    clear_phases();
    for (int j = 0; j < NUM_MODS; j++) begin
      mod_harm[j]  = 0;
      mod_depth[j] = 0;
    end
    car_harm    = longint'(CARRIER_HARM_RST);
    active_mods = 0;
    mod_sel     = 0;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CARRIER_HARM: car_harm = longint'(data[HARM_W-1:0]);
      REG_ACTIVE_MODS:  active_mods = int'(data[MOD_CNT_W-1:0]);
      REG_MOD_SELECT:   mod_sel = int'(data[MOD_IDX_W-1:0]);
      REG_MOD_HARM: begin
        mod_harm[mod_sel] = longint'(data[HARM_W-1:0]);
        clear_phases();
      end
      REG_MOD_DEPTH:    mod_depth[mod_sel] = longint'(signed'(data[DEPTH_W-1:0]));
      default: ;
    endcase
  endtask

  // one sample: modulators all read at their old phases, summed onto the old carrier phase
  task automatic step_voice(input longint step, output logic [SAMPLE_W-1:0] sample);
    longint swept;
    int     n;
    n     = (active_mods > NUM_MODS) ? NUM_MODS : active_mods;
    swept = car_phase;
    car_phase = (car_phase + ((step * car_harm) >>> 8)) & PHASE_MASK;
    for (int j = 0; j < n; j++) begin
      swept = swept + ((interp_sine(mod_phase[j]) * mod_depth[j] * TABLE_SIZE) >>> 15);
      mod_phase[j] = (mod_phase[j] + ((step * mod_harm[j]) >>> 8)) & PHASE_MASK;
    end
    sample = SAMPLE_W'(interp_sine(swept & PHASE_MASK));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_voice();
      expected_samples.delete();
      errors = 0;
    end else begin
      // results first: a result at this edge belongs to an earlier request
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          if (errors < REPORT_LIMIT) begin
            $display("unexpected sample %0d, none pending", $signed(out_tdata));
          end
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (want !== out_tdata) begin
            if (errors < REPORT_LIMIT) begin
              $display("sample mismatch: expected %0d, got %0d",
                       $signed(want), $signed(out_tdata));
            end
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_write(cfg_index, cfg_data);
      end
      if (in_tvalid && in_tready) begin
        step_voice(longint'(signed'(in_tdata[STEP_W-1:0])), predicted);
        expected_samples.push_back(predicted);
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_samples.size();
  end

endmodule

>>> tb/tb_fm_oscillator_parallel_modulators.sv
module tb_fm_oscillator_parallel_modulators;
  import fmo_pkg::*;

  localparam int RST_CYCLES   = 10;
  // limit sits well above the worst request plus output stalls on each side
  localparam int QUIET_LIMIT  = 1000;
  localparam int SETTLE       = 4;
  localparam int TAIL_CYCLES  = 80;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 150;

  localparam logic [STEP_W-1:0] STEP_MAX = {1'b0, {(STEP_W-1){1'b1}}};
  localparam logic [STEP_W-1:0] STEP_MIN = {1'b1, {(STEP_W-1){1'b0}}};
  localparam logic [STEP_W-1:0] STEP_ONE = {{(STEP_W-1){1'b0}}, 1'b1};
  localparam logic [STEP_W-1:0] STEP_ENTRY = STEP_ONE << FRAC_W;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  wire                   in_tready;
  wire                   out_tvalid;
  wire  [SAMPLE_W-1:0]   out_tdata;
  wire                   cfg_ready;

  int   mismatch_count;
  int   pending_count;
  int   quiet_cycles = 0;
  int   stall_left   = 0;
  logic idle_en      = 1'b1;

  always #5 clk = ~clk;

  fm_oscillator_parallel_modulators dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predicts every sample from the observed requests and config writes.
  fmo_sample_check u_sample_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // Output backpressure: random bursts of low ready while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drop the request line and wait until every predicted sample is out.
  // The first edge lets the pending count catch up with the last request.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Config writes only land while the block is idle.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // One step request; an optional gap first. Returns right after the accepting edge
  // with tvalid still high so back-to-back requests keep the line up.
  task automatic send_step(input logic [STEP_W-1:0] step);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-STEP_W){1'b0}}, step};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [STEP_W-1:0] pick_step();
    logic [31:0]       r;
    logic [STEP_W-1:0] mag;
    r = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2: return r[STEP_W-1:0];
      3: begin
        case (r[2:0])
          3'd0:    return '0;
          3'd1:    return STEP_MAX;
          3'd2:    return STEP_MIN;
          3'd3:    return '1;
          default: return STEP_ONE;
        endcase
      end
      default: begin
        // audio-rate steps: up to 64 entries per sample, either sign
        r   = $urandom_range(0, 32'h40_0000);
        mag = r[STEP_W-1:0];
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic logic [HARM_W-1:0] pick_harm();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return r[HARM_W-1:0];
      default: begin
        r = $urandom_range(0, 1023);
        return r[HARM_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    logic [31:0]        r;
    logic [DEPTH_W-1:0] d;
    r = $urandom();
    case ($urandom_range(0, 6))
      0:       return {1'b0, {(DEPTH_W-1){1'b1}}};
      1:       return {1'b1, {(DEPTH_W-1){1'b0}}};
      2:       return r[DEPTH_W-1:0];
      3:       return '0;
      default: begin
        // modest index, up to a quarter revolution per unit sine
        r = $urandom_range(0, 16384);
        d = r[DEPTH_W-1:0];
        return ($urandom_range(0, 1) != 0) ? -d : d;
      end
    endcase
  endfunction

  // New voice: carrier, modulator table entries, active count, stray writes.
  task automatic shuffle_voice();
    logic [31:0] r;
    logic [31:0] junk;
    r = $urandom();
    case ($urandom_range(0, 5))
      0:       cfg_write(REG_CARRIER_HARM, '0);
      1:       cfg_write(REG_CARRIER_HARM, {8'h00, 16'hFFFF});
      2:       cfg_write(REG_CARRIER_HARM, r[CFG_DATA_W-1:0]);
      default: cfg_write(REG_CARRIER_HARM, {8'h00, pick_harm()});
    endcase
    for (int j = 0; j < NUM_MODS; j++) begin
      if ($urandom_range(0, 1) != 0) begin
        r = j;
        cfg_write(REG_MOD_SELECT, r[CFG_DATA_W-1:0]);
        cfg_write(REG_MOD_HARM, {8'h00, pick_harm()});
        cfg_write(REG_MOD_DEPTH, pick_depth());
      end
    end
    r = $urandom();
    case ($urandom_range(0, 7))
      0:       cfg_write(REG_ACTIVE_MODS, r[CFG_DATA_W-1:0]);    // junk above bit 3
      1: begin
        r = $urandom_range(NUM_MODS + 1, 15);                   // clamps to all eight
        cfg_write(REG_ACTIVE_MODS, r[CFG_DATA_W-1:0]);
      end
      default: begin
        r = $urandom_range(0, NUM_MODS);
        cfg_write(REG_ACTIVE_MODS, r[CFG_DATA_W-1:0]);
      end
    endcase
    // select left pointing anywhere, sometimes with junk in the upper bits
    r = $urandom();
    cfg_write(REG_MOD_SELECT, r[CFG_DATA_W-1:0]);
    if ($urandom_range(0, 3) == 0) begin
      r    = $urandom_range(1, 3);
      junk = $urandom();
      cfg_write(REG_MOD_DEPTH + r[CFG_IDX_W-1:0], junk[CFG_DATA_W-1:0]); // unknown index
    end
  endtask

  initial begin : stimulus
    logic [31:0] r;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    // reset voice: carrier at 1.0, no modulators
    send_step('0);
    send_step(STEP_MAX);
    send_step(STEP_MIN);
    send_step(STEP_ONE);
    send_step('1);
    send_step(STEP_ENTRY);

    // carrier harmonic extremes
    cfg_write(REG_CARRIER_HARM, {8'h00, 16'hFFFF});
    send_step(STEP_MAX);
    send_step(STEP_MIN);
    send_step(STEP_ENTRY + STEP_ONE);
    cfg_write(REG_CARRIER_HARM, '0);
    send_step(STEP_ENTRY);

    // every modulator at full harmonic, depth at alternating extremes;
    // active count above the modulator count must clamp
    for (int j = 0; j < NUM_MODS; j++) begin
      r = j;
      cfg_write(REG_MOD_SELECT, r[CFG_DATA_W-1:0]);
      cfg_write(REG_MOD_HARM, {8'h00, 16'hFFFF});
      cfg_write(REG_MOD_DEPTH, (j % 2 == 1) ? {1'b1, {(DEPTH_W-1){1'b0}}}
                                            : {1'b0, {(DEPTH_W-1){1'b1}}});
    end
    cfg_write(REG_ACTIVE_MODS, {{(CFG_DATA_W-MOD_CNT_W){1'b0}}, {MOD_CNT_W{1'b1}}});
    cfg_write(REG_CARRIER_HARM, {8'h00, CARRIER_HARM_RST});
    send_step(STEP_MAX);
    send_step(STEP_MIN);
    send_step(STEP_ENTRY);
    send_step('0);

    // writes to unused indexes must leave the voice alone
    for (int k = 1; k <= 3; k++) begin
      r = k;
      cfg_write(REG_MOD_DEPTH + r[CFG_IDX_W-1:0], '1);
    end
    send_step(STEP_ENTRY);

    // harmonic write mid-voice clears every phase; depth write does not
    r = 2;
    cfg_write(REG_MOD_SELECT, r[CFG_DATA_W-1:0]);
    cfg_write(REG_MOD_HARM, {8'h00, 16'h0300});
    send_step(STEP_ENTRY);
    send_step(STEP_ENTRY);
    cfg_write(REG_MOD_DEPTH, {8'h00, 16'h4000});
    send_step(STEP_ENTRY);
    send_step(STEP_MIN);

    // exactly all modulators, then a single one
    r = NUM_MODS;
    cfg_write(REG_ACTIVE_MODS, r[CFG_DATA_W-1:0]);
    send_step(STEP_ENTRY);
    r = 1;
    cfg_write(REG_ACTIVE_MODS, r[CFG_DATA_W-1:0]);
    send_step(STEP_MAX);

    // ---- random phases ----
    // phase 4 and the last two run with no idling on either side
    for (int p = 0; p < PHASES; p++) begin
      idle_en <= (p != 4) && (p < PHASES - 2);
      shuffle_voice();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 59) == 0) begin
          r = $urandom();
          cfg_write(REG_MOD_SELECT, r[CFG_DATA_W-1:0]);
          if (r[31]) begin
            cfg_write(REG_MOD_HARM, {8'h00, pick_harm()});
          end else begin
            cfg_write(REG_MOD_DEPTH, pick_depth());
          end
        end
        send_step(pick_step());
      end
    end

    // ---- wrap up ----
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> fm_oscillator_parallel_modulators.f
hw/rtl/fmo_pkg.sv
hw/rtl/fmo_mul.sv
hw/rtl/fmo_sine.sv
hw/rtl/fmo_cfg.sv
hw/rtl/fm_oscillator_parallel_modulators.sv
tb/fmo_sample_check.sv
tb/tb_fm_oscillator_parallel_modulators.sv
